@@ design/minibatch_linear_regression_sgd_assert.svh @@
// Assertion macros for the minibatch linear regression trainer
`ifndef MINIBATCH_LINEAR_REGRESSION_SGD_ASSERT_SVH
`define MINIBATCH_LINEAR_REGRESSION_SGD_ASSERT_SVH

// check a property outside reset
`define MLRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define MLRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mlrs_pkg.sv @@
// Shared types, constants and saturation helpers for the regression trainer
package mlrs_pkg;

  localparam int LANES = 8;

  localparam logic OP_TRAIN   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  localparam logic [2:0] REG_LR     = 3'd0;
  localparam logic [2:0] REG_L1     = 3'd1;
  localparam logic [2:0] REG_L2     = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_NF     = 3'd4;
  localparam logic [2:0] REG_BATCH  = 3'd5;
  localparam logic [2:0] REG_BIAS   = 3'd6;

  localparam int MODE_L1 = 0;
  localparam int MODE_L2 = 1;

  localparam logic signed [63:0] G_LIM     = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] NEG_G_LIM = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] S64_MAX   = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic                        train;
    logic                        last;
    logic signed [31:0]          target;
    logic [LANES-1:0][31:0]      feat;
  } mlrs_item_t;

  typedef struct packed {
    logic [15:0]        lr;
    logic [15:0]        l1;
    logic [15:0]        l2;
    logic [1:0]         mode;
    logic [3:0]         nf;
    logic [5:0]         bsize;
    logic               bias_load;
    logic signed [31:0] bias_init;
  } mlrs_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      res = v[31:0];
    end else if (v[63]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

@@ design/minibatch_linear_regression_sgd.sv @@
// Predict runs the dot product; train also runs the error and gradient passes, and a transaction
// that ends a batch adds an update pass over each lane and the bias before out_tvalid.
// Throughput: one item at a time through a shared 32x32 multiplier lane loop.
// Batch update divides with an 8-bit-per-cycle divider.
// Two-entry input queue accepts, while it has a free entry, as the back end works or the result waits.
// Reset (sync, active low): state cleared, bias = 0, configuration at defaults; no clearing pass.
module minibatch_linear_regression_sgd import mlrs_pkg::*; #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_BATCH    = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // feature_0..feature_7, target
  input  logic         in_tuser,   // op
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [319:0] out_tdata,  // prediction, weight_0..weight_7, bias_out
  output logic         out_tuser,  // update_done
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic [15:0] lr_r, l1_r, l2_r;
  logic [1:0]  mode_r;
  logic [3:0]  nf_r;
  logic [5:0]  bsize_r;
  mlrs_cfg_t   cfg;
  logic        head_valid;
  mlrs_item_t  head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= 16'd655;
      l1_r    <= 16'd655;
      l2_r    <= 16'd655;
      mode_r  <= 2'd0;
      nf_r    <= 4'd8;
      bsize_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LR:    lr_r    <= cfg_wdata[15:0];
        REG_L1:    l1_r    <= cfg_wdata[15:0];
        REG_L2:    l2_r    <= cfg_wdata[15:0];
        REG_MODE:  mode_r  <= cfg_wdata[1:0];
        REG_NF:    nf_r    <= cfg_wdata[3:0];
        REG_BATCH: bsize_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.lr        = lr_r;
    cfg.l1        = l1_r;
    cfg.l2        = l2_r;
    cfg.mode      = mode_r;
    cfg.nf        = nf_r;
    cfg.bsize     = bsize_r;
    cfg.bias_load = rst_n && cfg_we && (cfg_addr == REG_BIAS);
    cfg.bias_init = cfg_wdata;
  end

  mlrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  mlrs_back #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_BATCH    (MAX_BATCH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ design/mlrs_front.sv @@
// Input side: accept transactions, classify them and queue them for the back end
module mlrs_front import mlrs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         head_valid,
  output mlrs_item_t   head,
  input  logic         pop
);

  mlrs_item_t  q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        do_pop;
  mlrs_item_t  item;

  always_comb begin
    item.train  = (in_tuser == OP_TRAIN);
    item.last   = in_tlast;
    item.target = in_tdata[287:256];
    for (int k = 0; k < LANES; k++) begin
      item.feat[k] = in_tdata[32*k +: 32];
    end
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end

endmodule

@@ design/mlrs_back.sv @@
// Back end: dot product, gradient accumulation, batch update and result register
module mlrs_back import mlrs_pkg::*; #(
  parameter int MAX_FEATURES = 8,
  parameter int MAX_BATCH    = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  mlrs_cfg_t    cfg,
  input  logic         head_valid,
  input  mlrs_item_t   head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [319:0] out_tdata,
  output logic         out_tuser
);

  localparam int CNT_W = $clog2(MAX_BATCH + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DOT   = 14'b00000000000010,
    S_PRED  = 14'b00000000000100,
    S_ERR   = 14'b00000000001000,
    S_GRAD  = 14'b00000000010000,
    S_DIVLD = 14'b00000000100000,
    S_DIV   = 14'b00000001000000,
    S_SIGN  = 14'b00000010000000,
    S_L1    = 14'b00000100000000,
    S_L2    = 14'b00001000000000,
    S_CLAMP = 14'b00010000000000,
    S_STEP  = 14'b00100000000000,
    S_APPLY = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t              state_r, state_nxt;
  mlrs_item_t          item_r;
  logic [3:0]          lane_r;
  logic [2:0]          plane_r;
  logic                pv_r;
  logic signed [63:0]  prod_r;
  logic signed [51:0]  acc_r;
  logic signed [31:0]  pred_r;
  logic signed [31:0]  err_r;
  logic                upd_r;
  logic signed [31:0]  w_r [LANES];
  logic signed [31:0]  bias_r;
  logic signed [63:0]  gs_r [LANES];
  logic signed [63:0]  bgs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [63:0]         q_r;
  logic [6:0]          rem_r;
  logic                neg_r;
  logic [2:0]          dstep_r;
  logic [3:0]          idx_r;
  logic signed [63:0]  g_r;
  logic signed [48:0]  gc_r;
  logic signed [49:0]  step_r;
  logic                out_valid_r;
  logic [319:0]        out_data_r;
  logic                out_user_r;

  logic [3:0]          nf_eff;
  logic [6:0]          bs7;
  logic [6:0]          eb7;
  logic [6:0]          n7;
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  mul_p;
  logic signed [65:0]  lr_p;
  logic signed [31:0]  wsel;
  logic signed [63:0]  l1_term;
  logic signed [63:0]  l2_term;
  logic [63:0]         src;
  logic [63:0]         div_q;
  logic [6:0]          div_r;
  logic [7:0]          r8;
  logic signed [31:0]  pred_c;
  logic signed [31:0]  err_c;
  logic signed [31:0]  val;
  logic                out_free;

  assign nf_eff = (cfg.nf > 4'(MAX_FEATURES)) ? 4'(MAX_FEATURES) : cfg.nf;
  assign bs7    = {1'b0, cfg.bsize};
  assign eb7    = (bs7 == 7'd0) ? 7'd1 : ((bs7 > 7'(MAX_BATCH)) ? 7'(MAX_BATCH) : bs7);
  assign n7     = 7'(cnt_r);
  assign wsel   = w_r[idx_r[2:0]];
  assign src    = idx_r[3] ? bgs_r : gs_r[idx_r[2:0]];
  assign val    = idx_r[3] ? bias_r : wsel;
  assign pop    = (state_r == S_IDLE) && head_valid;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    mul_a = w_r[lane_r[2:0]];
    mul_b = item_r.feat[lane_r[2:0]];
    case (state_r)
      S_GRAD: mul_a = err_r;
      S_SIGN: begin
        mul_a = $signed({16'd0, cfg.l2});
        mul_b = wsel;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign lr_p  = $signed({1'b0, cfg.lr}) * gc_r;

  assign pred_c = sat32(64'(acc_r) + 64'(bias_r));
  assign err_c  = sat32(64'(pred_r) - 64'(item_r.target));

  always_comb begin
    l1_term = '0;
    if (cfg.mode[MODE_L1] && !idx_r[3] && wsel != 32'sd0) begin
      l1_term = wsel[31] ? -$signed(64'(cfg.l1)) : $signed(64'(cfg.l1));
    end
    l2_term = '0;
    if (cfg.mode[MODE_L2] && !idx_r[3]) begin
      l2_term = prod_r >>> 16;
    end
  end

  always_comb begin
    div_r = rem_r;
    div_q = q_r;
    r8    = '0;
    for (int i = 0; i < 8; i++) begin
      r8    = {div_r, div_q[63]};
      div_q = {div_q[62:0], 1'b0};
      if (r8 >= {1'b0, n7}) begin
        r8       = r8 - {1'b0, n7};
        div_q[0] = 1'b1;
      end
      div_r = r8[6:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (head_valid) state_nxt = S_DOT;
      S_DOT:   if (lane_r >= nf_eff && !pv_r) state_nxt = S_PRED;
      S_PRED:  state_nxt = item_r.train ? S_ERR : S_OUT;
      S_ERR:   state_nxt = S_GRAD;
      S_GRAD:  if (lane_r >= nf_eff && !pv_r) state_nxt = upd_r ? S_DIVLD : S_OUT;
      S_DIVLD: state_nxt = S_DIV;
      S_DIV:   if (dstep_r == 3'd7) state_nxt = S_SIGN;
      S_SIGN:  state_nxt = S_L1;
      S_L1:    state_nxt = S_L2;
      S_L2:    state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_STEP;
      S_STEP:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = idx_r[3] ? S_OUT : S_DIVLD;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      bias_r      <= '0;
      bgs_r       <= '0;
      pv_r        <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        w_r[k]  <= '0;
        gs_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            item_r <= head;
            lane_r <= '0;
            pv_r   <= 1'b0;
            acc_r  <= '0;
          end
        end
        S_DOT, S_GRAD: begin
          if (lane_r < nf_eff) begin
            prod_r  <= mul_p;
            plane_r <= lane_r[2:0];
            pv_r    <= 1'b1;
            lane_r  <= lane_r + 4'd1;
          end else begin
            pv_r <= 1'b0;
          end
          if (state_r == S_DOT) begin
            if (pv_r) acc_r <= acc_r + 52'(prod_r >>> 16);
          end else begin
            if (pv_r) gs_r[plane_r] <= sat_add64(gs_r[plane_r], prod_r >>> 16);
            if (lane_r == 4'd0 && !pv_r) bgs_r <= sat_add64(bgs_r, 64'(err_r));
          end
          if (state_r == S_GRAD && lane_r >= nf_eff && !pv_r) begin
            idx_r <= (nf_eff == 4'd0) ? 4'd8 : 4'd0;
          end
        end
        S_PRED: begin
          pred_r <= pred_c;
          upd_r  <= 1'b0;
        end
        S_ERR: begin
          err_r  <= err_c;
          cnt_r  <= cnt_r + CNT_W'(1);
          upd_r  <= item_r.last || (n7 + 7'd1 >= eb7);
          lane_r <= '0;
          pv_r   <= 1'b0;
        end
        S_DIVLD: begin
          neg_r   <= src[63];
          q_r     <= src[63] ? -src : src;
          rem_r   <= '0;
          dstep_r <= '0;
        end
        S_DIV: begin
          q_r     <= div_q;
          rem_r   <= div_r;
          dstep_r <= dstep_r + 3'd1;
        end
        S_SIGN: begin
          g_r    <= neg_r ? -$signed(q_r) : $signed(q_r);
          prod_r <= mul_p;
        end
        S_L1: g_r <= sat_add64(g_r, l1_term);
        S_L2: g_r <= sat_add64(g_r, l2_term);
        S_CLAMP: begin
          if (g_r > G_LIM) begin
            gc_r <= 49'(G_LIM);
          end else if (g_r < NEG_G_LIM) begin
            gc_r <= 49'(NEG_G_LIM);
          end else begin
            gc_r <= 49'(g_r);
          end
        end
        S_STEP: step_r <= 50'(lr_p >>> 16);
        S_APPLY: begin
          if (idx_r[3]) begin
            bgs_r  <= '0;
            cnt_r  <= '0;
            for (int k = 0; k < LANES; k++) begin
              gs_r[k] <= '0;
            end
          end else begin
            w_r[idx_r[2:0]] <= sat32(64'(val) - 64'(step_r));
            idx_r <= (idx_r + 4'd1 < nf_eff) ? idx_r + 4'd1 : 4'd8;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_user_r  <= upd_r;
            out_data_r[31:0] <= pred_r;
            for (int k = 0; k < LANES; k++) begin
              out_data_r[32*(k+1) +: 32] <= w_r[k];
            end
            out_data_r[319:288] <= bias_r;
          end
        end
        default: ;
      endcase
      if (cfg.bias_load) begin
        bias_r <= cfg.bias_init;
      end else if (state_r == S_APPLY && idx_r[3]) begin
        bias_r <= sat32(64'(val) - 64'(step_r));
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ design/mlrs_checker.sv @@
// Port-level checks for the regression trainer and their binding
`include "minibatch_linear_regression_sgd_assert.svh"

module mlrs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [319:0] out_tdata,
  input logic         out_tuser
);

  `MLRS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `MLRS_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "result changed")
  `MLRS_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `MLRS_ASSERT_ALWAYS(a_rst_in, !rst_n |=> in_tready, "input not ready after reset")

endmodule

bind minibatch_linear_regression_sgd mlrs_checker u_chk (.*);
